// ===== src/bccs_pkg.sv =====
// Shared types and constants for the battery cell charge/OCV step block.
// Used by the controller, the datapath, the divider and the top level.
package bccs_pkg;

  localparam int TABLE_DEPTH = 32;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int DIV_W       = 62;
  localparam int DVS_W       = 28;
  localparam int CNT_W       = 6;

  localparam logic [13:0] SOC_FULL    = 14'd10000;
  localparam logic [11:0] SEC_PER_HR  = 12'd3600;
  localparam logic signed [23:0] CUR_MAX = 24'sh7FFFFF;
  localparam logic signed [23:0] CUR_MIN = 24'sh800000;
  localparam logic signed [47:0] CHG_MAX = 48'sh7FFFFFFFFFFF;
  localparam logic signed [47:0] CHG_MIN = 48'sh800000000000;

  localparam logic [1:0] FUNC_WRITE  = 2'd0;
  localparam logic [1:0] FUNC_REPORT = 2'd1;
  localparam logic [1:0] FUNC_TICK   = 2'd2;
  localparam logic [1:0] FUNC_RELOAD = 2'd3;

  localparam logic [1:0] MODE_CV = 2'd0;
  localparam logic [1:0] MODE_CC = 2'd1;

  localparam logic [1:0] REG_NOMINAL = 2'd0;
  localparam logic [1:0] REG_RESIST  = 2'd1;
  localparam logic [1:0] REG_INITIAL = 2'd2;
  localparam logic [1:0] REG_ENTRIES = 2'd3;

  typedef enum logic [1:0] {DIV_SOC, DIV_CV, DIV_INT} div_sel_t;

  typedef enum logic [3:0] {
    S_IDLE, S_LOAD, S_CHG_MUL, S_CHG_ADD, S_SOC_MUL, S_SOC_MUL2, S_SOC_GO,
    S_SOC_WAIT, S_WALK_RD, S_WALK_CHK, S_IDIV_GO, S_IDIV_WAIT, S_CDIV_GO,
    S_CDIV_WAIT, S_OUT
  } state_t;

  typedef struct packed {
    logic     capture;
    logic     ld_init;
    logic     chg_mul;
    logic     chg_add;
    logic     soc_mul;
    logic     soc_mul2;
    logic     soc_neg;
    logic     soc_fin;
    logic     walk_init;
    logic     walk_step;
    logic     ocv_take_rd;
    logic     ocv_take_div;
    logic     cur_take_div;
    logic     div_start;
    div_sel_t div_sel;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic rd_gt;
    logic idx_zero;
    logic idx_last;
    logic charge_neg;
  } stat_t;

endpackage

// ===== src/battery_cell_charge_ocv_step.sv =====
// Top level of the battery cell charge/OCV step block.
// Depends on bccs_pkg, bccs_ctrl, bccs_dp (which holds bccs_div).
//
// The block works on one word at a time. A table write (func 0) gives no
// result. Report and reload compute the state of charge and walk the table;
// a tick adds the charge update, and in constant voltage mode a second table
// walk and a 35-step division. The shared serial divider takes 62 steps for
// state of charge, 31 for the interpolation and 35 for the constant voltage
// current; the table walk reads each point through the single registered
// read port of the point memory. The result sits in an output register, so
// the next word is taken as soon as the state machine is back in idle even
// if the previous result has not been taken yet. Configuration writes are
// always taken, and must be made only while the block is idle. Table points
// never written read as undefined values; load every point below the active
// entry count before the first report or tick.
module battery_cell_charge_ocv_step (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_func,
  input  logic [4:0]         in_entry_index,
  input  logic [13:0]        in_entry_soc,
  input  logic [15:0]        in_entry_ocv,
  input  logic [1:0]         in_control_mode,
  input  logic signed [23:0] in_control_value,
  input  logic [15:0]        in_tick_seconds,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [31:0]        out_elapsed_seconds,
  output logic [15:0]        out_ocv_mv,
  output logic [13:0]        out_soc_centi,
  output logic signed [23:0] out_current_ma,
  output logic signed [47:0] out_charge_mas,
  output logic               out_soc_clamped,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);
  import bccs_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // Register writes never stall.
  assign cfg_ready = 1'b1;

  bccs_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_func, .in_control_mode, .out_ready,
    .stat, .cmd, .in_ready, .out_valid
  );

  bccs_dp u_dp (
    .clk, .rst_n, .cmd, .stat,
    .cfg_we(cfg_valid), .cfg_index, .cfg_data,
    .in_func, .in_entry_index, .in_entry_soc, .in_entry_ocv,
    .in_control_mode, .in_control_value, .in_tick_seconds,
    .out_elapsed_seconds, .out_ocv_mv, .out_soc_centi, .out_current_ma,
    .out_charge_mas, .out_soc_clamped
  );
endmodule

// ===== src/bccs_div.sv =====
// Restoring serial divider, one quotient bit per cycle.
// Depends on bccs_pkg for the operand widths.
module bccs_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [bccs_pkg::DIV_W-1:0]  dividend,
  input  logic [bccs_pkg::DVS_W-1:0]  divisor,
  input  logic [bccs_pkg::CNT_W-1:0]  count,
  output logic                        done,
  output logic [bccs_pkg::DIV_W-1:0]  quot
);
  import bccs_pkg::*;

  logic             busy_r, done_r;
  logic [DIV_W-1:0] dvd_r, quot_r;
  logic [DVS_W-1:0] rem_r, dsr_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DVS_W:0]   sh;
  logic             fits;

  // The dividend arrives left aligned, so count steps consume its value bits.
  assign sh   = {rem_r, dvd_r[DIV_W-1]};
  assign fits = sh >= {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == CNT_W'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r  <= dividend;
      dsr_r  <= divisor;
      rem_r  <= '0;
      quot_r <= '0;
      cnt_r  <= count;
    end else if (busy_r) begin
      dvd_r  <= {dvd_r[DIV_W-2:0], 1'b0};
      rem_r  <= fits ? DVS_W'(sh - {1'b0, dsr_r}) : sh[DVS_W-1:0];
      quot_r <= {quot_r[DIV_W-2:0], fits};
      cnt_r  <= cnt_r - CNT_W'(1);
    end
  end

  assign done = done_r;
  assign quot = quot_r;
endmodule

// ===== src/bccs_dp.sv =====
// Datapath: configuration registers, point table memory, charge state,
// multipliers and the shared serial divider. Depends on bccs_pkg, bccs_div.
module bccs_dp (
  input  logic                      clk,
  input  logic                      rst_n,
  input  bccs_pkg::cmd_t            cmd,
  output bccs_pkg::stat_t           stat,
  input  logic                      cfg_we,
  input  logic [1:0]                cfg_index,
  input  logic [15:0]               cfg_data,
  input  logic [1:0]                in_func,
  input  logic [4:0]                in_entry_index,
  input  logic [13:0]               in_entry_soc,
  input  logic [15:0]               in_entry_ocv,
  input  logic [1:0]                in_control_mode,
  input  logic signed [23:0]        in_control_value,
  input  logic [15:0]               in_tick_seconds,
  output logic [31:0]               out_elapsed_seconds,
  output logic [15:0]               out_ocv_mv,
  output logic [13:0]               out_soc_centi,
  output logic signed [23:0]        out_current_ma,
  output logic signed [47:0]        out_charge_mas,
  output logic                      out_soc_clamped
);
  import bccs_pkg::*;

  logic [15:0] nom_r, res_r, init_r;
  logic [5:0]  ent_r;
  logic [29:0] mem [TABLE_DEPTH];
  logic [29:0] rd_r;

  logic signed [23:0] cv_r, cur_r;
  logic [15:0]        dt_r, ocv_r, prev_ocv_r;
  logic signed [47:0] charge_r;
  logic [13:0]        soc_r, prev_soc_r;
  logic               flag_r, neg_r;
  logic [31:0]        time_r;
  logic [IDX_W-1:0]   idx_r, last_idx;
  logic signed [40:0] prod_r;
  logic [37:0]        mlo_r;
  logic [36:0]        mhi_r;
  logic [DVS_W-1:0]   den_r;

  logic [15:0]        nom_eff, res_eff;
  logic [13:0]        rd_soc;
  logic [15:0]        rd_ocv;
  logic signed [48:0] sum;
  logic signed [24:0] cv_diff;
  logic signed [34:0] cv_num;
  logic [34:0]        cv_mag;
  logic [13:0]        i_ds;
  logic signed [16:0] i_dv;
  logic signed [30:0] i_num;
  logic [30:0]        i_mag;
  logic [DIV_W-1:0]   dvd, quot;
  logic [DVS_W-1:0]   dvs;
  logic [CNT_W-1:0]   cnt;
  logic               dneg, div_done;
  logic [34:0]        q35;

  assign nom_eff = (nom_r == 16'd0) ? 16'd1 : nom_r;
  assign res_eff = (res_r == 16'd0) ? 16'd1 : res_r;
  assign rd_soc  = rd_r[29:16];
  assign rd_ocv  = rd_r[15:0];

  always_comb begin
    if (ent_r < 6'd2)                   last_idx = IDX_W'(1);
    else if (ent_r > 6'(TABLE_DEPTH))   last_idx = IDX_W'(TABLE_DEPTH - 1);
    else                                last_idx = IDX_W'(ent_r - 6'd1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nom_r  <= 16'd1000;
      res_r  <= 16'd100;
      init_r <= 16'd0;
      ent_r  <= 6'd2;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_NOMINAL: nom_r  <= cfg_data;
        REG_RESIST:  res_r  <= cfg_data;
        REG_INITIAL: init_r <= cfg_data;
        REG_ENTRIES: ent_r  <= cfg_data[5:0];
        default:     ;
      endcase
    end
  end

  // Point table: one write port from the input, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.capture && in_func == FUNC_WRITE) begin
      mem[in_entry_index[IDX_W-1:0]] <= {in_entry_soc, in_entry_ocv};
    end
    rd_r <= mem[idx_r];
  end

  // Divider operand selection.
  always_comb begin
    cv_diff = $signed({cv_r[23], cv_r}) - $signed({9'b0, ocv_r});
    cv_num  = $signed({{10{cv_diff[24]}}, cv_diff}) * 35'sd1000;
    cv_mag  = cv_num[34] ? 35'(-cv_num) : 35'(cv_num);
    i_ds    = soc_r - prev_soc_r;
    i_dv    = $signed({1'b0, rd_ocv}) - $signed({1'b0, prev_ocv_r});
    i_num   = $signed({17'b0, i_ds}) * $signed({{14{i_dv[16]}}, i_dv});
    i_mag   = i_num[30] ? 31'(-i_num) : 31'(i_num);
    case (cmd.div_sel)
      DIV_CV: begin
        dvd  = {cv_mag, 27'b0};
        dvs  = {12'b0, res_eff};
        cnt  = CNT_W'(35);
        dneg = cv_num[34];
      end
      DIV_INT: begin
        dvd  = {i_mag, 31'b0};
        dvs  = {14'b0, 14'(rd_soc - prev_soc_r)};
        cnt  = CNT_W'(31);
        dneg = i_num[30];
      end
      default: begin
        dvd  = DIV_W'({mhi_r, 24'b0}) + DIV_W'(mlo_r);
        dvs  = den_r;
        cnt  = CNT_W'(DIV_W);
        dneg = 1'b0;
      end
    endcase
  end

  bccs_div u_div (
    .clk, .rst_n,
    .start(cmd.div_start), .dividend(dvd), .divisor(dvs), .count(cnt),
    .done(div_done), .quot(quot)
  );

  assign sum = $signed({charge_r[47], charge_r}) + $signed({{8{prod_r[40]}}, prod_r});
  assign q35 = quot[34:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      charge_r <= '0;
      soc_r    <= '0;
      time_r   <= '0;
      flag_r   <= 1'b0;
    end else begin
      if (cmd.ld_init) begin
        charge_r <= 48'(init_r * SEC_PER_HR);
        time_r   <= '0;
      end
      if (cmd.chg_add) begin
        if (sum[48] != sum[47]) charge_r <= sum[48] ? CHG_MIN : CHG_MAX;
        else                    charge_r <= sum[47:0];
        time_r <= time_r + 32'(dt_r);
      end
      if (cmd.soc_neg) begin
        soc_r  <= '0;
        flag_r <= 1'b1;
      end
      if (cmd.soc_fin) begin
        if (quot > DIV_W'(SOC_FULL)) begin
          soc_r  <= SOC_FULL;
          flag_r <= 1'b1;
        end else begin
          soc_r  <= quot[13:0];
          flag_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cv_r  <= in_control_value;
      dt_r  <= in_tick_seconds;
      cur_r <= (in_func == FUNC_TICK && in_control_mode == MODE_CC) ?
               in_control_value : 24'sd0;
    end
    if (cmd.chg_mul)  prod_r <= cur_r * $signed({1'b0, dt_r});
    if (cmd.soc_mul) begin
      mlo_r <= charge_r[23:0] * SOC_FULL;
      den_r <= nom_eff * SEC_PER_HR;
    end
    if (cmd.soc_mul2) mhi_r <= charge_r[46:24] * SOC_FULL;
    if (cmd.div_start) neg_r <= dneg;
    if (cmd.walk_init) idx_r <= '0;
    if (cmd.walk_step) begin
      idx_r      <= idx_r + IDX_W'(1);
      prev_soc_r <= rd_soc;
      prev_ocv_r <= rd_ocv;
    end
    if (cmd.ocv_take_rd)  ocv_r <= rd_ocv;
    if (cmd.ocv_take_div) ocv_r <= prev_ocv_r + (neg_r ? 16'(-quot[15:0]) : quot[15:0]);
    if (cmd.cur_take_div) begin
      if (!neg_r) cur_r <= (q35 > 35'd8388607) ? CUR_MAX : $signed(q35[23:0]);
      else        cur_r <= (q35 > 35'd8388608) ? CUR_MIN : $signed(24'(-q35[23:0]));
    end
    if (cmd.out_load) begin
      out_elapsed_seconds <= time_r;
      out_ocv_mv          <= ocv_r;
      out_soc_centi       <= soc_r;
      out_current_ma      <= cur_r;
      out_charge_mas      <= charge_r;
      out_soc_clamped     <= flag_r;
    end
  end

  assign stat.div_done   = div_done;
  assign stat.rd_gt      = rd_soc > soc_r;
  assign stat.idx_zero   = idx_r == '0;
  assign stat.idx_last   = idx_r == last_idx;
  assign stat.charge_neg = charge_r[47];
endmodule

// ===== src/bccs_ctrl.sv =====
// Controller state machine sequencing one word through the datapath.
// Depends on bccs_pkg for the state, command and status types.
module bccs_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [1:0]       in_func,
  input  logic [1:0]       in_control_mode,
  input  logic             out_ready,
  input  bccs_pkg::stat_t  stat,
  output bccs_pkg::cmd_t   cmd,
  output logic             in_ready,
  output logic             out_valid
);
  import bccs_pkg::*;

  state_t state_r, state_nxt;
  logic   cvph_r, cvph_nxt;
  logic   ov_r, ov_nxt;
  logic   fire, slot_free;

  assign in_ready  = state_r == S_IDLE;
  assign fire      = in_valid && in_ready;
  assign slot_free = !ov_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cvph_r  <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cvph_r  <= cvph_nxt;
      ov_r    <= ov_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    cvph_nxt  = cvph_r;
    case (state_r)
      S_IDLE: begin
        if (fire) begin
          case (in_func)
            FUNC_REPORT: state_nxt = S_SOC_MUL;
            FUNC_TICK: begin
              if (in_control_mode == MODE_CV) begin
                state_nxt = S_WALK_RD;
                cvph_nxt  = 1'b1;
              end else begin
                state_nxt = S_CHG_MUL;
              end
            end
            FUNC_RELOAD: state_nxt = S_LOAD;
            default:     state_nxt = S_IDLE;
          endcase
        end
      end
      S_LOAD:     state_nxt = S_SOC_MUL;
      S_CHG_MUL:  state_nxt = S_CHG_ADD;
      S_CHG_ADD:  state_nxt = S_SOC_MUL;
      S_SOC_MUL:  state_nxt = S_SOC_MUL2;
      S_SOC_MUL2: state_nxt = S_SOC_GO;
      S_SOC_GO:   state_nxt = stat.charge_neg ? S_WALK_RD : S_SOC_WAIT;
      S_SOC_WAIT: if (stat.div_done) state_nxt = S_WALK_RD;
      S_WALK_RD:  state_nxt = S_WALK_CHK;
      S_WALK_CHK: begin
        if (stat.rd_gt && !stat.idx_zero) state_nxt = S_IDIV_GO;
        else if (stat.rd_gt || stat.idx_last) state_nxt = cvph_r ? S_CDIV_GO : S_OUT;
        else state_nxt = S_WALK_RD;
      end
      S_IDIV_GO:   state_nxt = S_IDIV_WAIT;
      S_IDIV_WAIT: if (stat.div_done) state_nxt = cvph_r ? S_CDIV_GO : S_OUT;
      S_CDIV_GO: begin
        state_nxt = S_CDIV_WAIT;
        cvph_nxt  = 1'b0;
      end
      S_CDIV_WAIT: if (stat.div_done) state_nxt = S_CHG_MUL;
      S_OUT:       if (slot_free) state_nxt = S_IDLE;
      default:     state_nxt = S_IDLE;
    endcase
  end

  // Commands.
  always_comb begin
    cmd         = '0;
    cmd.div_sel = DIV_SOC;
    ov_nxt      = ov_r && !out_ready;
    case (state_r)
      S_IDLE: begin
        cmd.capture   = fire;
        cmd.walk_init = fire;
      end
      S_LOAD:     cmd.ld_init  = 1'b1;
      S_CHG_MUL:  cmd.chg_mul  = 1'b1;
      S_CHG_ADD:  cmd.chg_add  = 1'b1;
      S_SOC_MUL:  cmd.soc_mul  = 1'b1;
      S_SOC_MUL2: cmd.soc_mul2 = 1'b1;
      S_SOC_GO: begin
        cmd.soc_neg   = stat.charge_neg;
        cmd.walk_init = stat.charge_neg;
        cmd.div_start = !stat.charge_neg;
      end
      S_SOC_WAIT: begin
        cmd.soc_fin   = stat.div_done;
        cmd.walk_init = stat.div_done;
      end
      S_WALK_CHK: begin
        cmd.ocv_take_rd = stat.rd_gt ? stat.idx_zero : stat.idx_last;
        cmd.walk_step   = !stat.rd_gt && !stat.idx_last;
      end
      S_IDIV_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_INT;
      end
      S_IDIV_WAIT: begin
        cmd.div_sel      = DIV_INT;
        cmd.ocv_take_div = stat.div_done;
      end
      S_CDIV_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_CV;
      end
      S_CDIV_WAIT: begin
        cmd.div_sel      = DIV_CV;
        cmd.cur_take_div = stat.div_done;
      end
      S_OUT: begin
        cmd.out_load = slot_free;
        if (slot_free) ov_nxt = 1'b1;
      end
      default: ;
    endcase
  end

  assign out_valid = ov_r;
endmodule

// ===== src/bccs_chk.sv =====
// Port-level checker for battery_cell_charge_ocv_step, bound to the top.
// Depends on bccs_pkg for the function codes and the full-scale constant.
module bccs_chk (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic [1:0]         in_func,
  input logic               out_valid,
  input logic               out_ready,
  input logic [31:0]        out_elapsed_seconds,
  input logic [13:0]        out_soc_centi,
  input logic signed [47:0] out_charge_mas,
  input logic               out_soc_clamped
);
  import bccs_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_elapsed_seconds))
    else $error("result word changed while stalled");

  a_soc_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_soc_centi <= SOC_FULL)
    else $error("state of charge above full scale");

  a_neg_charge: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_charge_mas[47] |-> out_soc_centi == 14'd0 && out_soc_clamped)
    else $error("negative charge not clamped to empty");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_func != FUNC_WRITE |=> !in_ready)
    else $error("block took a word while computing");
endmodule

bind battery_cell_charge_ocv_step bccs_chk u_bccs_chk (.*);
